// ===== src/ecn_pm_pkg.sv =====
// ecn_pm_pkg: item types, register map and constants of the ecn probabilistic marker
// depends on nothing; imported by ecn_probabilistic_marker
package ecn_pm_pkg;

  localparam int QB_W   = 24;
  localparam int PS_W   = 16;
  localparam int PROB_W = 11;
  localparam int LFSR_W = 32;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [PROB_W-1:0] PROB_ONE  = 11'd1024;
  localparam logic [LFSR_W-1:0] LFSR_TAPS = 32'h8020_0003;
  localparam logic [LFSR_W-1:0] LFSR_ONE  = 32'h0000_0001;

  localparam logic [2:0] REG_LOW_THR  = 3'd0;
  localparam logic [2:0] REG_HIGH_THR = 3'd1;
  localparam logic [2:0] REG_MAX_PROB = 3'd2;
  localparam logic [2:0] REG_BYTE_LIM = 3'd3;
  localparam logic [2:0] REG_SEED     = 3'd4;

  typedef struct packed {
    logic [QB_W-1:0] queue_bytes;
    logic [PS_W-1:0] packet_size;
    logic            is_ipv4;
  } ecn_in_t;

  typedef struct packed {
    logic mark;
    logic drop;
  } ecn_out_t;

endpackage

// ===== src/ecn_probabilistic_marker.sv =====
// ecn_probabilistic_marker: red-style congestion mark and byte-limit drop decision
// depends on ecn_pm_pkg (item types, register map, lfsr taps)
//
// usage
//   in_*  : one item per arriving packet (queue occupancy, size, ipv4 flag),
//           accepted when in_valid is high and in_stall is low
//   out_* : one item per input item with mark and drop, in input order,
//           taken when out_valid is high and out_stall is low
//   apb   : five registers at byte addresses 0,4,8,12,16 (low threshold,
//           high threshold, max probability, byte limit, random seed);
//           pready is always high, writing the seed reloads the generator
// timing
//   an accepted item waits in the input register and its result is loaded into
//   the result register, which raises out_valid; one item per cycle is sustained
//   while out_stall is low, set by the single compute stage between the two
//   registers (one add, two subtracts, four compares, two small multiplies and
//   one wide compare, with the lfsr step in the same stage)
// reset
//   synchronous active-low reset empties both registers and loads the
//   register reset values; the generator restarts from 1
// stall
//   a stalled result holds; one more item is taken into the input register,
//   then in_stall rises until the result is taken
module ecn_probabilistic_marker
  import ecn_pm_pkg::*;
#(
  parameter int COUNT_BITS = 24,
  parameter int RAND_BITS  = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ecn_in_t           in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ecn_out_t          out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int CW    = (COUNT_BITS < QB_W) ? COUNT_BITS : QB_W;
  localparam int NB_W  = CW + 1;
  localparam int LP_W  = RAND_BITS + CW;
  localparam int RP_W  = PROB_W + CW;
  localparam int CMP_W = RAND_BITS + CW + PROB_W;

  // configuration registers
  logic [CW-1:0]     low_thr_r;
  logic [CW-1:0]     high_thr_r;
  logic [PROB_W-1:0] max_prob_r;
  logic [CW-1:0]     byte_lim_r;
  logic [LFSR_W-1:0] seed_r;
  logic [LFSR_W-1:0] lfsr_r;
  logic [LFSR_W-1:0] lfsr_nxt;

  // pipeline registers
  logic     s1_valid_r;
  ecn_in_t  s1_data_r;
  logic     out_valid_r;
  ecn_out_t out_data_r;
  ecn_out_t res_nxt;

  logic cfg_wr;
  logic seed_wr;
  logic out_fire;
  logic s1_move;
  logic in_fire;

  logic [NB_W-1:0]   nbytes;
  logic              le_low;
  logic              ge_high;
  logic              in_band;
  logic [CW-1:0]     span;
  logic [CW-1:0]     over;
  logic [LFSR_W-1:0] lfsr_step;
  logic [RAND_BITS-1:0] rnd;
  logic [PROB_W-1:0] pmax;
  logic [LP_W-1:0]   lhs_prod;
  logic [RP_W-1:0]   rhs_prod;
  logic [CMP_W-1:0]  lhs;
  logic [CMP_W-1:0]  rhs;

  // handshake
  assign cfg_wr   = psel && penable && pwrite;
  assign seed_wr  = cfg_wr && (paddr[4:2] == REG_SEED);
  assign out_fire = out_valid_r && !out_stall;
  assign s1_move  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_move;
  assign in_fire  = in_valid && !in_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign pready    = 1'b1;

  // decision datapath
  assign nbytes  = {1'b0, s1_data_r.queue_bytes[CW-1:0]} + NB_W'(s1_data_r.packet_size);
  assign le_low  = nbytes <= {1'b0, low_thr_r};
  assign ge_high = nbytes >= {1'b0, high_thr_r};
  assign in_band = s1_data_r.is_ipv4 && !le_low && !ge_high;
  assign span    = high_thr_r - low_thr_r;
  assign over    = nbytes[CW-1:0] - low_thr_r;

  assign lfsr_step = {1'b0, lfsr_r[LFSR_W-1:1]} ^ (lfsr_r[0] ? LFSR_TAPS : '0);
  assign rnd       = lfsr_step[RAND_BITS-1:0];
  assign pmax      = (max_prob_r > PROB_ONE) ? PROB_ONE : max_prob_r;

  assign lhs_prod = {{CW{1'b0}}, rnd} * {{RAND_BITS{1'b0}}, span};
  assign rhs_prod = {{CW{1'b0}}, pmax} * {{PROB_W{1'b0}}, over};
  assign lhs      = {1'b0, lhs_prod, {(PROB_W-1){1'b0}}};
  assign rhs      = {rhs_prod, {RAND_BITS{1'b0}}};

  always_comb begin
    res_nxt.mark = s1_data_r.is_ipv4 && !le_low && (ge_high || (lhs < rhs));
    res_nxt.drop = nbytes > {1'b0, byte_lim_r};
  end

  always_comb begin
    lfsr_nxt = lfsr_r;
    if (seed_wr) begin
      lfsr_nxt = (pwdata == '0) ? LFSR_ONE : pwdata;
    end else if (s1_move && in_band) begin
      lfsr_nxt = lfsr_step;
    end
  end

  // control and configuration state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      low_thr_r   <= {{(CW-1){1'b1}}, 1'b0};
      high_thr_r  <= '1;
      max_prob_r  <= '0;
      byte_lim_r  <= '1;
      seed_r      <= LFSR_ONE;
      lfsr_r      <= LFSR_ONE;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_move) begin
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr) begin
        unique case (paddr[4:2])
          REG_LOW_THR:  low_thr_r  <= pwdata[CW-1:0];
          REG_HIGH_THR: high_thr_r <= pwdata[CW-1:0];
          REG_MAX_PROB: max_prob_r <= pwdata[PROB_W-1:0];
          REG_BYTE_LIM: byte_lim_r <= pwdata[CW-1:0];
          REG_SEED:     seed_r     <= pwdata;
          default: ;
        endcase
      end
      lfsr_r <= lfsr_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_data_r <= in_data;
    end
    if (s1_move) begin
      out_data_r <= res_nxt;
    end
  end

  // register readback
  always_comb begin
    unique case (paddr[4:2])
      REG_LOW_THR:  prdata = DATA_W'(low_thr_r);
      REG_HIGH_THR: prdata = DATA_W'(high_thr_r);
      REG_MAX_PROB: prdata = DATA_W'(max_prob_r);
      REG_BYTE_LIM: prdata = DATA_W'(byte_lim_r);
      REG_SEED:     prdata = seed_r;
      default:      prdata = '0;
    endcase
  end

  a_lfsr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    lfsr_r != '0)
    else $error("lfsr reached the all-zero state");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled while the pipeline can move");

  a_lfsr_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!seed_wr && !(s1_move && in_band)) |=> $stable(lfsr_r))
    else $error("lfsr advanced without an in-band item");

  a_no_mark_non_ipv4: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_move && !s1_data_r.is_ipv4) |=> !out_data_r.mark)
    else $error("mark set on a non-ipv4 item");

  a_high_marks: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_move && s1_data_r.is_ipv4 && ge_high && !le_low) |=> out_data_r.mark)
    else $error("no mark at or above the high threshold");

endmodule

// ===== verif/tb_ecn_probabilistic_marker.sv =====
// tb_ecn_probabilistic_marker: self-checking bench for the ecn probabilistic marker
// predicts mark and drop per packet from its own copy of the registers and lfsr
// depends on ecn_pm_pkg and ecn_probabilistic_marker
module tb_ecn_probabilistic_marker;
  import ecn_pm_pkg::*;

  localparam int RAND_W      = 10;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 4;
  localparam int MAX_REPORTS = 10;
  localparam int MAX_GAP     = 40;
  localparam logic [QB_W-1:0] QB_MAX = '1;
  localparam logic [PS_W-1:0] PS_MAX = '1;

  logic              clk      = 1'b0;
  logic              rst_n    = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  ecn_in_t           in_data  = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  ecn_out_t          out_data;
  logic              psel     = 1'b0;
  logic              penable  = 1'b0;
  logic              pwrite   = 1'b0;
  logic [ADDR_W-1:0] paddr    = '0;
  logic [DATA_W-1:0] pwdata   = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  logic [QB_W-1:0]   thr_low;
  logic [QB_W-1:0]   thr_high;
  logic [QB_W-1:0]   limit_bytes;
  logic [PROB_W-1:0] prob_max;
  logic [LFSR_W-1:0] gen_state;

  ecn_out_t pending_verdicts[$];

  int send_idle_pct    = 0;
  int stall_pct        = 0;
  int hold_left        = 0;
  int cycles           = 0;
  int fails            = 0;
  int items_sent       = 0;
  int verdicts_checked = 0;
  int band_draws       = 0;
  int marks_seen       = 0;
  int drops_seen       = 0;

  ecn_probabilistic_marker u_top (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d verdicts outstanding", cycles,
               pending_verdicts.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver: long hold-off when requested, else random stalls
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic note_fail(string msg);
    fails++;
    if (fails <= MAX_REPORTS) $display("%s", msg);
  endtask

  always @(posedge clk) begin
    ecn_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      verdicts_checked++;
      marks_seen += int'(out_data.mark);
      drops_seen += int'(out_data.drop);
      if (pending_verdicts.size() == 0) begin
        note_fail($sformatf("unexpected item mark=%0b drop=%0b",
                            out_data.mark, out_data.drop));
      end else begin
        want = pending_verdicts.pop_front();
        if (out_data.mark !== want.mark || out_data.drop !== want.drop)
          note_fail($sformatf("item %0d: expected mark=%0b drop=%0b, got mark=%0b drop=%0b",
                              verdicts_checked, want.mark, want.drop,
                              out_data.mark, out_data.drop));
      end
    end
  end

  function automatic ecn_out_t decide_packet(ecn_in_t it);
    logic [QB_W:0] nbytes;
    logic [63:0]   pmax;
    logic [63:0]   span;
    logic [63:0]   over;
    logic [63:0]   draw;
    ecn_out_t      res;
    nbytes   = {1'b0, it.queue_bytes} + (QB_W+1)'(it.packet_size);
    res.mark = 1'b0;
    if (it.is_ipv4) begin
      if (nbytes <= {1'b0, thr_low}) begin
        res.mark = 1'b0;
      end else if (nbytes >= {1'b0, thr_high}) begin
        res.mark = 1'b1;
      end else begin
        pmax = 64'((prob_max > PROB_ONE) ? PROB_ONE : prob_max);
        span = 64'(thr_high) - 64'(thr_low);
        over = 64'(nbytes) - 64'(thr_low);
        gen_state = gen_state[0] ? ((gen_state >> 1) ^ LFSR_TAPS) : (gen_state >> 1);
        draw = 64'(gen_state[RAND_W-1:0]);
        res.mark = (draw * 64'(PROB_ONE) * span) < ((pmax * over) << RAND_W);
        band_draws++;
      end
    end
    res.drop = nbytes > {1'b0, limit_bytes};
    return res;
  endfunction

  function automatic ecn_in_t make_item(logic [QB_W:0] total, logic ipv4);
    ecn_in_t     it;
    int unsigned lo;
    int unsigned hi;
    lo = (total > {1'b0, QB_MAX}) ? 32'(total - {1'b0, QB_MAX}) : 0;
    hi = (total > (QB_W+1)'(PS_MAX)) ? 32'(PS_MAX) : 32'(total);
    it.packet_size = PS_W'($urandom_range(hi, lo));
    it.queue_bytes = QB_W'(total - (QB_W+1)'(it.packet_size));
    it.is_ipv4     = ipv4;
    return it;
  endfunction

  // mostly packets landing in the marking band or around the byte limit
  function automatic ecn_in_t pick_item();
    int unsigned   mode;
    int unsigned   span;
    logic [QB_W:0] total;
    ecn_in_t       it;
    mode = $urandom_range(99);
    span = (thr_high > thr_low) ? 32'(thr_high - thr_low) : 2;
    if (mode < 80) begin
      if (mode < 60) total = (QB_W+1)'(32'(thr_low) + $urandom_range(span));
      else if (limit_bytes < 2) total = (QB_W+1)'($urandom_range(3));
      else total = (QB_W+1)'(32'(limit_bytes) + $urandom_range(4) - 2);
      it = make_item(total, $urandom_range(99) < 85);
    end else begin
      it.queue_bytes = QB_W'($urandom);
      it.packet_size = PS_W'($urandom);
      it.is_ipv4     = 1'($urandom);
    end
    return it;
  endfunction

  task automatic send_item(ecn_in_t it);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    pending_verdicts.push_back(decide_packet(it));
    items_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [DATA_W-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_LOW_THR:  thr_low     = val[QB_W-1:0];
      REG_HIGH_THR: thr_high    = val[QB_W-1:0];
      REG_MAX_PROB: prob_max    = val[PROB_W-1:0];
      REG_BYTE_LIM: limit_bytes = val[QB_W-1:0];
      REG_SEED:     gen_state   = (val == '0) ? LFSR_ONE : val;
      default: ;
    endcase
  endtask

  task automatic set_marking(int unsigned lo, int unsigned hi, int unsigned pmax,
                             int unsigned lim, logic [DATA_W-1:0] seed);
    wait_idle();
    write_reg(REG_LOW_THR, lo);
    write_reg(REG_HIGH_THR, hi);
    write_reg(REG_MAX_PROB, pmax);
    write_reg(REG_BYTE_LIM, lim);
    write_reg(REG_SEED, seed);
  endtask

  task automatic test_reset_values();
    send_item(ecn_in_t'{QB_MAX, PS_MAX, 1'b1});
    send_item(ecn_in_t'{'0, '0, 1'b0});
    send_item(ecn_in_t'{QB_MAX - 1, '0, 1'b1});
    send_item(ecn_in_t'{QB_MAX, '0, 1'b1});
  endtask

  task automatic test_unused_registers();
    wait_idle();
    for (int i = int'(REG_SEED) + 1; i < (1 << $bits(REG_SEED)); i++)
      write_reg(3'(i), '0);
    send_item(ecn_in_t'{QB_MAX, '0, 1'b1});
  endtask

  task automatic test_band_edges();
    set_marking(1000, 2000, 32'(PROB_ONE), 1500, 32'h1234_5678);
    send_item(make_item(1000, 1'b1));
    send_item(make_item(1001, 1'b1));
    send_item(make_item(1999, 1'b1));
    send_item(make_item(2000, 1'b1));
    send_item(make_item(1500, 1'b0));
    send_item(make_item(1500, 1'b1));
    send_item(make_item(1501, 1'b1));
    send_item(ecn_in_t'{'0, PS_MAX, 1'b1});
  endtask

  task automatic test_prob_saturation();
    wait_idle();
    write_reg(REG_MAX_PROB, DATA_W'({PROB_W{1'b1}}));
    repeat (3) send_item(make_item((QB_W+1)'(1500 + $urandom_range(400)), 1'b1));
    wait_idle();
    write_reg(REG_MAX_PROB, '0);
    repeat (2) send_item(make_item(1999, 1'b1));
  endtask

  task automatic test_zero_seed();
    wait_idle();
    write_reg(REG_MAX_PROB, DATA_W'(PROB_ONE >> 1));
    write_reg(REG_SEED, '0);
    repeat (2) send_item(make_item(1900, 1'b1));
  endtask

  task automatic test_inverted_thresholds();
    set_marking(3000, 2000, 32'(PROB_ONE), 0, 32'hDEAD_BEEF);
    send_item(make_item(2500, 1'b1));
    send_item(make_item(3000, 1'b1));
    send_item(make_item(3001, 1'b1));
    wait_idle();
    write_reg(REG_LOW_THR, 2000);
    send_item(make_item(2000, 1'b1));
    send_item(make_item(2001, 1'b1));
  endtask

  task automatic run_random_phase(int n, int idle_pct, int stall);
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    repeat (n) send_item(pick_item());
  endtask

  task automatic test_random_full_band();
    set_marking(0, 32'(QB_MAX), 32'(PROB_ONE), 32'(QB_MAX) - $urandom_range(32'(PS_MAX)),
                '1);
    run_random_phase(210, 0, 0);
  endtask

  task automatic test_random_sender_gaps();
    int unsigned lo;
    lo = $urandom_range(1 << 23);
    set_marking(lo, lo + $urandom_range(4096, 1), $urandom_range(2047),
                lo + $urandom_range(8192), $urandom);
    run_random_phase(210, 79, 0);
  endtask

  task automatic test_random_receiver_stalls();
    int unsigned lo;
    lo = $urandom_range(32'(QB_MAX) - 64);
    set_marking(lo, lo + $urandom_range(64, 2), $urandom_range(32'(PROB_ONE)),
                $urandom, $urandom);
    run_random_phase(210, 0, 79);
  endtask

  task automatic test_random_light_idling();
    int unsigned lo;
    lo = $urandom_range(32'(QB_MAX) - 32'(PS_MAX));
    set_marking(lo, lo + $urandom_range(32'(PS_MAX), 1), 32'(PROB_ONE >> 1),
                lo + $urandom_range(32'(PS_MAX)), $urandom);
    run_random_phase(210, 9, 9);
  endtask

  task automatic test_input_backpressure();
    wait_idle();
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_left     = 60;
    repeat (40) send_item(pick_item());
    wait_idle();
    repeat (10) send_item(pick_item());
  endtask

  initial begin
    thr_low     = QB_MAX - 1;
    thr_high    = QB_MAX;
    prob_max    = '0;
    limit_bytes = QB_MAX;
    gen_state   = LFSR_ONE;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_values();
    test_unused_registers();
    test_band_edges();
    test_prob_saturation();
    test_zero_seed();
    test_inverted_thresholds();
    test_random_full_band();
    test_random_sender_gaps();
    test_random_receiver_stalls();
    test_random_light_idling();
    test_input_backpressure();

    wait_idle();
    repeat (8) @(posedge clk);
    $display("%0d packets sent, %0d verdicts checked: %0d marked, %0d dropped, %0d band draws",
             items_sent, verdicts_checked, marks_seen, drops_seen, band_draws);
    $display("reset values, band edges, saturation, zero seed, inverted band, backpressure");
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", fails);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/ecn_pm_pkg.sv
src/ecn_probabilistic_marker.sv
verif/tb_ecn_probabilistic_marker.sv
